// ===== src/fgl_pkg.sv =====
// ---------------------------------------------------------------------------
// fgl_pkg: shared types and constants for the FONTX2 glyph locator
// Register indexes, sequencer states and fixed offsets of the font image.
// ---------------------------------------------------------------------------
`default_nettype none

package fgl_pkg;

   // code block table
   localparam int MAX_BLOCKS = 128;
   localparam int SLOT_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = 8;

   // field widths
   localparam int CODE_W   = 16;
   localparam int OFFSET_W = 29;
   localparam int GB_W     = 14;
   localparam int PIX_W    = 8;

   // stream payload widths (packed, padded to bytes)
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   // font image layout
   localparam logic [OFFSET_W-1:0] ANK_BASE  = OFFSET_W'(17);
   localparam logic [OFFSET_W-1:0] DBCS_BASE = OFFSET_W'(18);
   localparam logic [CODE_W-1:0]   SMALL_CODE_LIMIT = CODE_W'(16'h0100);

   // commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_CELL_WIDTH  = 2'd0,
      REG_CELL_HEIGHT = 2'd1,
      REG_SINGLE_BYTE = 2'd2,
      REG_BLOCK_COUNT = 2'd3
   } fgl_reg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_MULT,
      ST_FINISH
   } fgl_state_type;

endpackage

`default_nettype wire

// ===== src/fontx_glyph_locator_core.sv =====
// ---------------------------------------------------------------------------
// fontx_glyph_locator_core: FONTX2 glyph offset lookup
// Holds the code block table and walks it with one compare/accumulate unit;
// one shared multiplier scales the glyph index by the glyph size.
// ---------------------------------------------------------------------------
//   channel  direction  transaction
//   req_*    in         load one code block (tuser=0) or look up a code (tuser=1)
//   rsp_*    out        one result per lookup, none per load
//   csr_*    in         write one configuration register, no read-back
//
// A load is written to the block table from the idle state. A lookup of a small
// code in a single-byte font goes through the multiply step to the finish step,
// and a lookup that misses at once goes straight to the finish step. A double-
// byte lookup walks up to 128 blocks, reading one block entry per cycle from the
// block table memory; a hit goes on to the multiply step, then the finish step.
// Reset is synchronous; it clears the sequencer, the result valid and the
// configuration registers. The block table is not cleared.
// req_tready is high only between lookups; a result waiting on rsp_tready does
// not block the next accept, but it holds the next lookup in its last step.
// ---------------------------------------------------------------------------
`default_nettype none

module fontx_glyph_locator_core
   import fgl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // block_slot, block_start,
                                                  // block_end, char_code, pad
   input  wire logic                  req_tuser,  // cmd
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // glyph_offset, glyph_width,
                                                  // glyph_height, pad
   output logic                       rsp_tuser,  // found
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [7:0]            csr_wdata
);

   // request fields
   logic [SLOT_W-1:0] req_slot;
   logic [CODE_W-1:0] req_start;
   logic [CODE_W-1:0] req_end;
   logic [CODE_W-1:0] req_code;

   assign req_slot  = req_tdata[6:0];
   assign req_start = req_tdata[22:7];
   assign req_end   = req_tdata[38:23];
   assign req_code  = req_tdata[54:39];

   // configuration registers
   logic [PIX_W-1:0] cell_width_ff;
   logic [PIX_W-1:0] cell_height_ff;
   logic             single_byte_ff;
   logic [CNT_W-1:0] block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= PIX_W'(8);
         cell_height_ff <= PIX_W'(16);
         single_byte_ff <= 1'b0;
         block_count_ff <= '0;
      end else if (csr_we) begin
         case (fgl_reg_type'(csr_addr))
            REG_CELL_WIDTH:  cell_width_ff  <= csr_wdata;
            REG_CELL_HEIGHT: cell_height_ff <= csr_wdata;
            REG_SINGLE_BYTE: single_byte_ff <= csr_wdata[0];
            REG_BLOCK_COUNT: block_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   fgl_state_type       state_ff,    state_in;
   logic [CODE_W-1:0]   code_ff,     code_in;
   logic [CNT_W-1:0]    walk_ff,     walk_in;
   logic [SLOT_W-1:0]   idx_ff,      idx_in;
   logic [OFFSET_W-1:0] passed_ff,   passed_in;
   logic [OFFSET_W-1:0] mul_a_ff,    mul_a_in;
   logic [GB_W-1:0]     gb_ff,       gb_in;
   logic [OFFSET_W-1:0] base_ff,     base_in;
   logic [OFFSET_W-1:0] prod_ff,     prod_in;
   logic                hit_ff,      hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [PIX_W-1:0]    rsp_width_ff,  rsp_width_in;
   logic [PIX_W-1:0]    rsp_height_ff, rsp_height_in;

   // block table memory, one registered read per cycle
   logic [CODE_W-1:0] range_first_mem [MAX_BLOCKS];
   logic [CODE_W-1:0] range_last_mem  [MAX_BLOCKS];
   logic [CODE_W-1:0] rd_lo_ff;
   logic [CODE_W-1:0] rd_hi_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              tbl_we;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         range_first_mem[req_slot] <= req_start;
         range_last_mem[req_slot]  <= req_end;
      end
      rd_lo_ff <= range_first_mem[rd_addr];
      rd_hi_ff <= range_last_mem[rd_addr];
   end

   // glyph size: bytes per row times rows
   logic [PIX_W:0]   width_pad;
   logic [5:0]       row_bytes;
   logic [GB_W-1:0]  glyph_bytes;

   assign width_pad   = {1'b0, cell_width_ff} + (PIX_W+1)'(7);
   assign row_bytes   = width_pad[PIX_W:3];
   assign glyph_bytes = row_bytes * cell_height_ff;

   // shared multiplier
   logic [OFFSET_W+GB_W-1:0] mul_full;
   assign mul_full = mul_a_ff * gb_ff;

   // compare/accumulate unit of the walk
   logic                in_block;
   logic [OFFSET_W-1:0] block_size;
   logic [OFFSET_W-1:0] hit_idx;
   logic                walk_last;

   assign in_block   = (code_ff >= rd_lo_ff) && (code_ff <= rd_hi_ff);
   assign block_size = {13'b0, rd_hi_ff} - {13'b0, rd_lo_ff} + OFFSET_W'(1);
   assign hit_idx    = passed_ff + OFFSET_W'(code_ff - rd_lo_ff);
   assign walk_last  = ({1'b0, idx_ff} + CNT_W'(1)) == walk_ff;

   logic rsp_free;
   logic rsp_load;
   logic req_accept;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      walk_in       = walk_ff;
      idx_in        = idx_ff;
      passed_in     = passed_ff;
      mul_a_in      = mul_a_ff;
      gb_in         = gb_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      hit_in        = hit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_height_in = rsp_height_ff;
      rsp_load      = 1'b0;
      tbl_we        = 1'b0;
      rd_addr       = '0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            code_in    = req_code;
            gb_in      = glyph_bytes;
            idx_in     = '0;
            passed_in  = '0;
            hit_in     = 1'b0;
            walk_in    = (block_count_ff > CNT_W'(MAX_BLOCKS)) ?
                         CNT_W'(MAX_BLOCKS) : block_count_ff;
            if (req_accept) begin
               if (req_tuser == CMD_LOAD) begin
                  tbl_we = 1'b1;
               end else if (req_code < SMALL_CODE_LIMIT) begin
                  // single-byte code: direct index
                  mul_a_in = {21'b0, req_code[7:0]};
                  base_in  = ANK_BASE;
                  hit_in   = single_byte_ff;
                  state_in = single_byte_ff ? ST_MULT : ST_FINISH;
               end else begin
                  // double-byte code: walk the block table from slot 0
                  base_in  = DBCS_BASE + {19'b0, block_count_ff, 2'b00};
                  state_in = (single_byte_ff || (walk_in == '0)) ?
                             ST_FINISH : ST_WALK;
               end
            end
         end

         ST_WALK: begin
            rd_addr = idx_ff + SLOT_W'(1);
            if (in_block) begin
               mul_a_in = hit_idx;
               hit_in   = 1'b1;
               state_in = ST_MULT;
            end else begin
               passed_in = passed_ff + block_size;
               idx_in    = idx_ff + SLOT_W'(1);
               if (walk_last) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_MULT: begin
            prod_in  = mul_full[OFFSET_W-1:0];
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_found_in  = hit_ff;
               rsp_offset_in = hit_ff ? (prod_ff + base_ff) : '0;
               rsp_width_in  = hit_ff ? cell_width_ff  : '0;
               rsp_height_in = hit_ff ? cell_height_ff : '0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      walk_ff       <= walk_in;
      idx_ff        <= idx_in;
      passed_ff     <= passed_in;
      mul_a_ff      <= mul_a_in;
      gb_ff         <= gb_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      hit_ff        <= hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_height_ff <= rsp_height_in;
   end

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {3'b000, rsp_height_ff, rsp_width_ff, rsp_offset_ff};

   // walk index stays inside the clamped walk length
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_ff != '0) && ({1'b0, idx_ff} < walk_ff))
      else $error("walk index outside block count");

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("miss result with nonzero payload");

   // finishing a lookup presents a result next cycle
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("finished lookup did not present a result");

endmodule

`default_nettype wire

// ===== tb/sv/glyph_locator_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_locator_checker: scoreboard for the FONTX2 glyph locator
// Watches the request, response and register ports, keeps its own copy of
// the code block table and font registers, works out the answer to every
// accepted lookup and compares the responses in order, field by field.
// ---------------------------------------------------------------------------
module glyph_locator_checker
   import fgl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // block_slot, block_start,
                                              // block_end, char_code, pad
   input  logic                  req_tuser,   // cmd
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // glyph_offset, glyph_width,
                                              // glyph_height, pad
   input  logic                  rsp_tuser,   // found
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [7:0]            csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    results_seen,
   output int                    found_seen
);

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] offset;
      logic [PIX_W-1:0]    width;
      logic [PIX_W-1:0]    height;
   } glyph_result_type;

   // shadow copy of the font registers and the code block table
   logic [PIX_W-1:0]  font_width;
   logic [PIX_W-1:0]  font_height;
   logic              font_single;
   logic [CNT_W-1:0]  font_blocks;
   logic [CODE_W-1:0] block_lo [MAX_BLOCKS];
   logic [CODE_W-1:0] block_hi [MAX_BLOCKS];

   glyph_result_type glyphs_due [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      results_seen   = 0;
      found_seen     = 0;
   end

   // where the glyph for this code sits in the font image, or not found
   function automatic glyph_result_type locate_glyph(input logic [CODE_W-1:0] code);
      glyph_result_type res;
      logic [31:0]   glyph_bytes;
      logic [31:0]   offset;
      logic [31:0]   passed;
      logic [31:0]   walk;
      logic [31:0]   lo;
      logic [31:0]   hi;
      logic          hit;
      res    = '0;
      hit    = 1'b0;
      offset = '0;
      passed = '0;
      glyph_bytes = ((32'(font_width) + 32'd7) / 32'd8) * 32'(font_height);
      if (code < SMALL_CODE_LIMIT) begin
         if (font_single) begin
            hit    = 1'b1;
            offset = 32'(ANK_BASE) + 32'(code) * glyph_bytes;
         end
      end else if (!font_single) begin
         // walk stops at the table size; offset still uses the register
         walk = (32'(font_blocks) > 32'(MAX_BLOCKS)) ?
                32'(MAX_BLOCKS) : 32'(font_blocks);
         for (int i = 0; i < walk && !hit; i++) begin
            lo = 32'(block_lo[i]);
            hi = 32'(block_hi[i]);
            if (32'(code) >= lo && 32'(code) <= hi) begin
               hit    = 1'b1;
               offset = 32'(DBCS_BASE) + 32'd4 * 32'(font_blocks)
                        + (passed + (32'(code) - lo)) * glyph_bytes;
            end else begin
               passed = passed + (hi - lo + 32'd1);
            end
         end
      end
      if (hit) begin
         res.found  = 1'b1;
         res.offset = offset[OFFSET_W-1:0];
         res.width  = font_width;
         res.height = font_height;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      glyph_result_type want;
      logic [SLOT_W-1:0] slot;
      logic [OFFSET_W-1:0] got_offset;
      logic [PIX_W-1:0] got_width;
      logic [PIX_W-1:0] got_height;
      if (reset) begin
         font_width  = 8'd8;
         font_height = 8'd16;
         font_single = 1'b0;
         font_blocks = '0;
         glyphs_due.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (fgl_reg_type'(csr_addr))
               REG_CELL_WIDTH:  font_width  = csr_wdata;
               REG_CELL_HEIGHT: font_height = csr_wdata;
               REG_SINGLE_BYTE: font_single = csr_wdata[0];
               REG_BLOCK_COUNT: font_blocks = csr_wdata;
               default: ;
            endcase
         end

         // response transaction against the oldest expected glyph
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (rsp_tuser) found_seen <= found_seen + 1;
            got_offset = rsp_tdata[OFFSET_W-1:0];
            got_width  = rsp_tdata[OFFSET_W +: PIX_W];
            got_height = rsp_tdata[OFFSET_W+PIX_W +: PIX_W];
            if (glyphs_due.size() == 0) begin
               $error("unexpected response: found %0d offset 0x%0h",
                      rsp_tuser, got_offset);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = glyphs_due.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
                  mismatch_count = mismatch_count + 1;
               end
               if (got_offset !== want.offset) begin
                  $error("glyph_offset: expected 0x%0h, actual 0x%0h",
                         want.offset, got_offset);
                  mismatch_count = mismatch_count + 1;
               end
               if (got_width !== want.width) begin
                  $error("glyph_width: expected %0d, actual %0d",
                         want.width, got_width);
                  mismatch_count = mismatch_count + 1;
               end
               if (got_height !== want.height) begin
                  $error("glyph_height: expected %0d, actual %0d",
                         want.height, got_height);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end

         // request transaction: load a block or queue the lookup answer
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_LOAD) begin
               slot = req_tdata[SLOT_W-1:0];
               block_lo[slot] = req_tdata[SLOT_W +: CODE_W];
               block_hi[slot] = req_tdata[SLOT_W+CODE_W +: CODE_W];
            end else begin
               glyphs_due.push_back(locate_glyph(req_tdata[SLOT_W+2*CODE_W +: CODE_W]));
            end
         end
      end
      pending_count <= glyphs_due.size();
   end

endmodule

// ===== tb/sv/tb_fontx_glyph_locator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fontx_glyph_locator_core: testbench for the FONTX2 glyph locator
// Drives loads and lookups with random gaps and response stalls, switches
// the font registers between phases, and leaves prediction and comparison
// to the checker beside the block.
// ---------------------------------------------------------------------------
module tb_fontx_glyph_locator_core;
   import fgl_pkg::*;

   localparam int CLOCK_HALF  = 4;
   localparam int SETTLE      = 140;       // longest lookup walk plus margin
   localparam int ITEM_BUDGET = 1100;
   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // block_slot, block_start,
                                            // block_end, char_code, pad
   logic                  req_tuser  = 1'b0; // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // glyph_offset, glyph_width,
                                            // glyph_height, pad
   logic                  rsp_tuser;        // found
   logic                  csr_we     = 1'b0;
   logic [1:0]            csr_addr   = '0;
   logic [7:0]            csr_wdata  = '0;

   int mismatch_count;
   int pending_count;
   int results_seen;
   int found_seen;

   // stimulus bookkeeping
   logic [CODE_W-1:0] plan_lo [MAX_BLOCKS];
   logic [CODE_W-1:0] plan_hi [MAX_BLOCKS];
   int   table_walk   = 0;
   logic font_single  = 1'b0;
   int   block_cursor = 16'h8140;
   int   loads_sent   = 0;
   int   lookups_sent = 0;
   int   phases       = 0;
   logic req_idling   = 1'b1;
   logic rsp_idling   = 1'b1;
   int   rsp_stall    = 0;

   fontx_glyph_locator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   glyph_locator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .results_seen   (results_seen),
      .found_seen     (found_seen)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // response backpressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!rsp_idling || r < 65) begin
         rsp_tready <= 1'b1;
      end else if (r < 94) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b0;
         rsp_stall  <= $urandom_range(10, 40);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_idling || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_pixels();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'd0;
      if (r < 3)  return 8'd1;
      if (r < 5)  return 8'd255;
      if (r < 10) return 8'($urandom_range(1, 3) * 8);
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] pick_block_count();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd128;
      if (r == 2) return 8'($urandom_range(129, 255));
      return 8'($urandom_range(1, 24));
   endfunction

   // lookup code aimed at the loaded blocks, their edges, or anywhere
   function automatic logic [CODE_W-1:0] pick_code();
      int r;
      int s;
      r = $urandom_range(0, 99);
      if (font_single) begin
         return (r < 70) ? CODE_W'($urandom_range(0, 255)) :
                           CODE_W'($urandom_range(0, 65535));
      end
      if (table_walk > 0 && r < 65) begin
         s = $urandom_range(0, table_walk - 1);
         if (r < 55) begin
            if (plan_lo[s] <= plan_hi[s])
               return plan_lo[s] +
                      CODE_W'($urandom_range(0, int'(plan_hi[s] - plan_lo[s])));
            return plan_lo[s];
         end
         return $urandom_range(0, 1) ? plan_lo[s] - 1'b1 : plan_hi[s] + 1'b1;
      end
      if (r < 80) return CODE_W'($urandom_range(0, 255));
      return CODE_W'($urandom_range(0, 65535));
   endfunction

   // next block of a well-formed table, now and then an arbitrary pair
   task automatic make_block(output logic [CODE_W-1:0] lo, output logic [CODE_W-1:0] hi);
      int b_lo;
      int b_hi;
      if ($urandom_range(0, 15) == 0) begin
         lo = CODE_W'($urandom);
         hi = CODE_W'($urandom);
      end else begin
         if (block_cursor > 16'hFF00) block_cursor = $urandom_range(16'h8140, 16'h9000);
         b_lo = block_cursor + $urandom_range(0, 16);
         b_hi = b_lo + $urandom_range(0, 188);
         if (b_lo > 16'hFFFF) b_lo = 16'hFFFF;
         if (b_hi > 16'hFFFF) b_hi = 16'hFFFF;
         lo = CODE_W'(b_lo);
         hi = CODE_W'(b_hi);
         block_cursor = b_hi + 1;
      end
   endtask

   // one request transaction; valid stays high into the next one on no gap
   task automatic send_req(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [CODE_W-1:0] lo, input logic [CODE_W-1:0] hi,
                           input logic [CODE_W-1:0] code);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, code, hi, lo, slot};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] lo,
                            input logic [CODE_W-1:0] hi);
      plan_lo[slot] = lo;
      plan_hi[slot] = hi;
      loads_sent++;
      send_req(CMD_LOAD, slot, lo, hi, CODE_W'($urandom));
   endtask

   task automatic send_lookup(input logic [CODE_W-1:0] code);
      lookups_sent++;
      send_req(CMD_LOOKUP, SLOT_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), code);
   endtask

   // wait until every lookup has answered and the block has gone quiet
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_font(input logic [7:0] w, input logic [7:0] h, input logic single,
                           input logic [7:0] count);
      quiesce();
      csr_we    <= 1'b1;
      csr_addr  <= REG_CELL_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= REG_CELL_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_addr  <= REG_SINGLE_BYTE;
      csr_wdata <= {7'd0, single};
      @(posedge clock);
      csr_addr  <= REG_BLOCK_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
      font_single = single;
      table_walk  = (int'(count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
      phases++;
   endtask

   initial begin
      int random_items;
      int n;
      int s;
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
      random_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single-byte font: code extremes, double-byte codes miss
      set_font(8'd8, 8'd16, 1'b1, 8'd0);
      send_lookup(16'h0000);
      send_lookup(16'h00FF);
      send_lookup(16'h0041);
      send_lookup(16'h0100);
      send_lookup(16'hFFFF);

      // double-byte font: normal, reversed and full-range blocks, largest cells
      set_font(8'd255, 8'd255, 1'b0, 8'd3);
      send_load(7'd0, 16'h8140, 16'h817E);
      send_load(7'd1, 16'h9000, 16'h8F00);
      send_load(7'd2, 16'h8F00, 16'hFFFF);
      send_load(7'd127, 16'h0000, 16'hFFFF);
      send_lookup(16'h8140);
      send_lookup(16'h817E);
      send_lookup(16'h817F);
      send_lookup(16'h9000);
      send_lookup(16'hFFFF);
      send_lookup(16'h00FF);
      send_lookup(16'h0100);

      // zero-size glyphs in both font types
      set_font(8'd0, 8'd255, 1'b1, 8'd128);
      send_lookup(16'h0041);
      set_font(8'd1, 8'd0, 1'b0, 8'd2);
      send_lookup(16'h8150);

      // random phases: fresh registers, refill the walked slots, then traffic
      while (random_items < ITEM_BUDGET) begin
         rsp_idling <= ($urandom_range(0, 3) != 0);
         req_idling  = ($urandom_range(0, 3) != 0);
         set_font(pick_pixels(), pick_pixels(), ($urandom_range(0, 3) == 0),
                  pick_block_count());
         block_cursor = $urandom_range(16'h8140, 16'h9000);
         for (s = 0; s < table_walk; s++) begin
            make_block(lo, hi);
            send_load(SLOT_W'(s), lo, hi);
            random_items++;
         end
         n = $urandom_range(10, 40);
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               make_block(lo, hi);
               send_load(SLOT_W'($urandom_range(0, MAX_BLOCKS - 1)), lo, hi);
            end else begin
               send_lookup(pick_code());
            end
            random_items++;
         end
      end

      quiesce();
      $display("Covered %0d register phases with %0d block loads and %0d lookups",
               phases, loads_sent, lookups_sent);
      $display("Checked %0d responses: %0d found, %0d not found",
               results_seen, found_seen, results_seen - found_seen);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
